// ===== design/ps2kd_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2kd_pkg
// Shared constants, codes and control/status types for the PS/2 keyboard
// device unit.
// ----------------------------------------------------------------------------
package ps2kd_pkg;

	localparam int REP_W   = 6;
	localparam int TOTAL_W = REP_W + 1;

	localparam logic [REP_W-1:0] MAX_REPEAT = REP_W'(32);

	// host commands
	localparam logic [7:0] CMD_SET_LEDS  = 8'hED;
	localparam logic [7:0] CMD_ECHO      = 8'hEE;
	localparam logic [7:0] CMD_SCAN_SET  = 8'hF0;
	localparam logic [7:0] CMD_READ_ID   = 8'hF2;
	localparam logic [7:0] CMD_TYPEMATIC = 8'hF3;
	localparam logic [7:0] CMD_ENABLE    = 8'hF4;
	localparam logic [7:0] CMD_DISABLE   = 8'hF5;
	localparam logic [7:0] CMD_ACK_LO    = 8'hF6;
	localparam logic [7:0] CMD_ACK_HI    = 8'hFE;
	localparam logic [7:0] CMD_RESET     = 8'hFF;

	// device bytes
	localparam logic [7:0] BYTE_ACK   = 8'hFA;
	localparam logic [7:0] BYTE_BAT   = 8'hAA;
	localparam logic [7:0] BYTE_ERR   = 8'hFE;
	localparam logic [7:0] BYTE_E0    = 8'hE0;
	localparam logic [7:0] KEY_BREAK  = 8'h80;

	// response run kinds
	localparam logic [2:0] RSP_ACK  = 3'd0;
	localparam logic [2:0] RSP_ECHO = 3'd1;
	localparam logic [2:0] RSP_ID   = 3'd2;
	localparam logic [2:0] RSP_RST  = 3'd3;
	localparam logic [2:0] RSP_ERR  = 3'd4;
	localparam logic [2:0] RSP_KEY  = 3'd5;

	localparam logic KIND_HOST = 1'b0;

	typedef struct packed {
		logic capture;
		logic load;
		logic emit;
	} ctl_t;

	typedef struct packed {
		logic run_empty;
		logic at_last;
		logic out_free;
	} stat_t;

endpackage

// ===== design/ps2_keyboard_device_unit.sv =====
// ----------------------------------------------------------------------------
// ps2_keyboard_device_unit
// Device side of a PS/2 keyboard: host commands and key events in, response
// bytes out with a last marker on the final byte of each run.
// ----------------------------------------------------------------------------
// An item produces n response bytes (0 to 64): it is taken, then decoded,
// then its bytes go out one per cycle into the single output register
// while the sink keeps up. Key events with reporting off or a zero repeat
// count produce no bytes; they are taken and decoded only.
// keyboard_id is written through the cfg channel, which is always ready.
module ps2_keyboard_device_unit
	import ps2kd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// cmd_byte[7:0], scan_code[15:8], key_down[16], enhanced[17], repeat_count[23:18]
	input  logic [23:0] s_axis_tdata,
	// kind[0]
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// data_byte[7:0]
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	ctl_t  ctl;
	stat_t stat;

	assign cfg_ready = 1'b1;

	ps2kd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.ctl           (ctl)
	);

	ps2kd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== design/ps2kd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ps2kd_ctrl
// Sequencer: takes an item, has the datapath evaluate it, then steps the
// response bytes out one per cycle while the output register is free.
// ----------------------------------------------------------------------------
module ps2kd_ctrl
	import ps2kd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_axis_tvalid,
	output logic  s_axis_tready,
	input  stat_t stat,
	output ctl_t  ctl
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] st_q;
	logic [1:0] st_n;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign ctl.capture   = s_axis_tvalid && s_axis_tready;
	assign ctl.load      = (st_q == ST_LOAD);
	assign ctl.emit      = (st_q == ST_EMIT) && stat.out_free;

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (ctl.capture) st_n = ST_LOAD;
			end
			ST_LOAD: begin
				st_n = stat.run_empty ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (ctl.emit && stat.at_last) st_n = ST_IDLE;
			end
			default: st_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else         st_q <= st_n;
	end

	a_empty_run_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_LOAD && stat.run_empty) |=> st_q == ST_IDLE)
		else $error("empty run did not return to idle");

	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && stat.at_last) |=> s_axis_tready)
		else $error("not ready after final byte");

endmodule

// ===== design/ps2kd_dp.sv =====
// ----------------------------------------------------------------------------
// ps2kd_dp
// Datapath: item registers, command decode, keyboard state bits, run
// counter and output register.
// ----------------------------------------------------------------------------
module ps2kd_dp
	import ps2kd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output stat_t       stat,
	input  logic [23:0] s_axis_tdata,
	input  logic [0:0]  s_axis_tuser,
	input  logic        cfg_valid,
	input  logic [7:0]  cfg_data,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast
);

	logic               kind_q;
	logic [7:0]         cmd_q;
	logic [7:0]         scan_q;
	logic               down_q;
	logic               ext_q;
	logic [REP_W-1:0]   rep_q;

	logic [7:0]         kbd_id_q;
	logic               report_q;
	logic               await_q;

	logic [2:0]         rsp_q;
	logic [TOTAL_W-1:0] total_q;
	logic [REP_W-1:0]   idx_q;

	logic               out_valid_q;
	logic [7:0]         out_data_q;
	logic               out_last_q;

	logic [2:0]         rsp_n;
	logic               await_n;
	logic               report_n;
	logic [REP_W-1:0]   reps_sat;
	logic [TOTAL_W-1:0] key_total;
	logic [TOTAL_W-1:0] total_n;
	logic [7:0]         key_code;
	logic [7:0]         byte_n;
	logic               last_n;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			kind_q <= s_axis_tuser[0];
			cmd_q  <= s_axis_tdata[7:0];
			scan_q <= s_axis_tdata[15:8];
			down_q <= s_axis_tdata[16];
			ext_q  <= s_axis_tdata[17];
			rep_q  <= s_axis_tdata[23:18];
		end
	end

	// evaluation of the captured item
	assign reps_sat  = (rep_q > MAX_REPEAT) ? MAX_REPEAT : rep_q;
	assign key_total = !report_q ? '0 :
		ext_q ? {reps_sat, 1'b0} : {1'b0, reps_sat};
	assign key_code  = down_q ? scan_q : (scan_q | KEY_BREAK);

	always_comb begin
		rsp_n    = RSP_ACK;
		await_n  = await_q;
		report_n = report_q;
		if (kind_q != KIND_HOST) begin
			rsp_n = RSP_KEY;
		end else if (await_q) begin
			await_n = 1'b0;
		end else begin
			unique case (cmd_q) inside
				CMD_SET_LEDS, CMD_SCAN_SET, CMD_TYPEMATIC: await_n = 1'b1;
				CMD_ECHO:                  rsp_n = RSP_ECHO;
				CMD_READ_ID:               rsp_n = RSP_ID;
				CMD_ENABLE:                report_n = 1'b1;
				CMD_DISABLE:               report_n = 1'b0;
				[CMD_ACK_LO:CMD_ACK_HI]:   rsp_n = RSP_ACK;
				CMD_RESET:                 rsp_n = RSP_RST;
				default:                   rsp_n = RSP_ERR;
			endcase
		end
	end

	always_comb begin
		case (rsp_n)
			RSP_ID:  total_n = TOTAL_W'(2);
			RSP_RST: total_n = TOTAL_W'(3);
			RSP_KEY: total_n = key_total;
			default: total_n = TOTAL_W'(1);
		endcase
	end

	// byte at the current run position
	always_comb begin
		case (rsp_q)
			RSP_ECHO: byte_n = CMD_ECHO;
			RSP_ERR:  byte_n = BYTE_ERR;
			RSP_ID:   byte_n = (idx_q == '0) ? BYTE_ACK : kbd_id_q;
			RSP_RST: begin
				if (idx_q == '0)                 byte_n = BYTE_ACK;
				else if (idx_q == REP_W'(1))     byte_n = BYTE_BAT;
				else                             byte_n = kbd_id_q;
			end
			RSP_KEY:  byte_n = (ext_q && !idx_q[0]) ? BYTE_E0 : key_code;
			default:  byte_n = BYTE_ACK;
		endcase
	end

	assign last_n = (TOTAL_W'({1'b0, idx_q}) + TOTAL_W'(1)) == total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kbd_id_q <= '0;
			report_q <= 1'b0;
			await_q  <= 1'b0;
			rsp_q    <= RSP_ACK;
			total_q  <= '0;
			idx_q    <= '0;
		end else begin
			if (cfg_valid) kbd_id_q <= cfg_data;
			if (ctl.load) begin
				report_q <= report_n;
				await_q  <= await_n;
				rsp_q    <= rsp_n;
				total_q  <= total_n;
				idx_q    <= '0;
			end else if (ctl.emit) begin
				idx_q <= idx_q + REP_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_data_q <= byte_n;
			out_last_q <= last_n;
		end
	end

	assign stat.run_empty = (total_n == '0);
	assign stat.at_last   = last_n;
	assign stat.out_free  = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	a_emit_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> TOTAL_W'({1'b0, idx_q}) < total_q)
		else $error("byte emitted past end of run");

	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && last_n) |=> (m_axis_tvalid && m_axis_tlast))
		else $error("final byte lost its last marker");

	a_await_set: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(await_q) |-> ($past(cmd_q) == CMD_SET_LEDS ||
			$past(cmd_q) == CMD_SCAN_SET || $past(cmd_q) == CMD_TYPEMATIC))
		else $error("data wait set by wrong command");

	a_await_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.load && kind_q == KIND_HOST && await_q) |=> !await_q)
		else $error("data byte did not end the wait");

endmodule
